// File: rtl/wsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared widths, constants and types of the world-to-screen projection pipe.
// ----------------------------------------------------------------------------
package wsp_pkg;

    // fixed-point format of matrix entries, positions and screen values
    localparam int FRAC_BITS = 16;
    localparam int ENTRY_W   = 32;
    localparam int PROD_W    = 2 * ENTRY_W;
    // exact sum of three products
    localparam int SUM_W     = PROD_W + 2;
    // clip value after the shift back to FRAC_BITS, plus the bias column
    localparam int CLIP_W    = SUM_W - FRAC_BITS;
    // divisor (clip w, known positive when the point is visible)
    localparam int DIV_W     = CLIP_W - 1;
    // dividend magnitude |clip| * 2^FRAC_BITS
    localparam int NUM_W     = CLIP_W + FRAC_BITS;
    // quotient bits kept; anything at or above 2^QB saturates the screen value
    localparam int QB        = FRAC_BITS + 17;
    localparam int CMP_W     = DIV_W + QB;
    localparam int NDC_W     = QB + 2;

    // screen mapping
    localparam int SIZE_W    = 16;
    localparam int HALF_W    = SIZE_W - 1;
    localparam int COEF_W    = SIZE_W + 1;
    localparam int SPROD_W   = COEF_W + NDC_W;
    localparam int SCR_W     = SPROD_W + 1;
    localparam int OUT_W     = 32;

    // visibility threshold: round(0.1 * 2^FRAC_BITS)
    localparam longint W_MIN = ((longint'(1) << FRAC_BITS) + 5) / 10;

    // configuration port
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 16'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 16'd1080;

    // request operations
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    // matrix
    localparam int MAT_DEPTH = 16;
    localparam int IDX_W     = 4;

    // sideband that travels with every pipeline stage
    typedef struct packed {
        logic valid;
        logic visible;
    } t_tag;

endpackage

// File: rtl/wsp_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_clip
// View matrix store and clip-space transform: two stages (products, row sums).
// ----------------------------------------------------------------------------
module wsp_clip import wsp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_accept,
    input  logic                     i_operation,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic signed [ENTRY_W-1:0] i_entry_value,
    input  logic signed [ENTRY_W-1:0] i_pos_x,
    input  logic signed [ENTRY_W-1:0] i_pos_y,
    input  logic signed [ENTRY_W-1:0] i_pos_z,
    output t_tag                     o_tag,
    output logic signed [CLIP_W-1:0] o_clip_x,
    output logic signed [CLIP_W-1:0] o_clip_y,
    output logic signed [CLIP_W-1:0] o_clip_w
);

    logic signed [ENTRY_W-1:0] r_matrix [MAT_DEPTH];
    logic signed [PROD_W-1:0]  r_prod   [3][3];
    logic signed [ENTRY_W-1:0] r_bias   [3];
    t_tag                      r_tag1;
    logic signed [CLIP_W-1:0]  r_clip   [3];
    t_tag                      r_tag2;
    logic signed [ENTRY_W-1:0] pos      [3];
    logic signed [CLIP_W-1:0]  n_clip   [3];

    assign pos[0] = i_pos_x;
    assign pos[1] = i_pos_y;
    assign pos[2] = i_pos_z;

    // write one matrix entry per load request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < MAT_DEPTH; e++) begin
                r_matrix[e] <= '0;
            end
        end else if (i_accept && (i_operation == OP_LOAD)) begin
            r_matrix[i_entry_index] <= i_entry_value;
        end
    end

    // stage 1: nine products of rows 0, 1 and 3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
        end else if (i_en) begin
            r_tag1.valid   <= i_accept && (i_operation == OP_PROJECT);
            r_tag1.visible <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= PROD_W'(pos[c])
                                  * PROD_W'(r_matrix[((r == 2) ? 3 : r) * 4 + c]);
                end
                r_bias[r] <= r_matrix[((r == 2) ? 3 : r) * 4 + 3];
            end
        end
    end

    // sum exact products, floor back to FRAC_BITS, add the fourth column
    always_comb begin
        logic signed [SUM_W-1:0] s;
        for (int r = 0; r < 3; r++) begin
            s = {{2{r_prod[r][0][PROD_W-1]}}, r_prod[r][0]}
              + {{2{r_prod[r][1][PROD_W-1]}}, r_prod[r][1]}
              + {{2{r_prod[r][2][PROD_W-1]}}, r_prod[r][2]};
            n_clip[r] = $signed(s[SUM_W-1:FRAC_BITS])
                      + $signed({{(CLIP_W-ENTRY_W){r_bias[r][ENTRY_W-1]}}, r_bias[r]});
        end
    end

    // stage 2: clip values and visibility
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2 <= '0;
        end else if (i_en) begin
            r_tag2.valid   <= r_tag1.valid;
            r_tag2.visible <= n_clip[2] >= CLIP_W'(W_MIN);
            for (int r = 0; r < 3; r++) begin
                r_clip[r] <= n_clip[r];
            end
        end
    end

    assign o_tag    = r_tag2;
    assign o_clip_x = r_clip[0];
    assign o_clip_y = r_clip[1];
    assign o_clip_w = r_clip[2];

endmodule

// File: rtl/wsp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_div
// Pipelined restoring divider, two lanes sharing the divisor clip w:
// ndc = floor(clip * 2^FRAC_BITS / w), one quotient bit per stage.
// ----------------------------------------------------------------------------
module wsp_div import wsp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_tag                     i_tag,
    input  logic signed [CLIP_W-1:0] i_clip_x,
    input  logic signed [CLIP_W-1:0] i_clip_y,
    input  logic signed [CLIP_W-1:0] i_clip_w,
    output t_tag                     o_tag,
    output logic signed [NDC_W-1:0]  o_ndc_x,
    output logic signed [NDC_W-1:0]  o_ndc_y
);

    logic [NUM_W-1:0] r_rem [2][QB+1];
    logic [QB-1:0]    r_quo [2][QB+1];
    logic             r_neg [2][QB+1];
    logic             r_ovf [2][QB+1];
    logic [DIV_W-1:0] r_div [QB+1];
    t_tag             r_tag [QB+1];

    logic [NUM_W-1:0] n_rem  [2][QB+1];
    logic             n_take [2][QB+1];
    logic [NUM_W-1:0] mag_in [2];
    logic             neg_in [2];
    logic             ovf_in [2];
    logic signed [NDC_W-1:0] n_ndc [2];

    t_tag                    r_tag_out;
    logic signed [NDC_W-1:0] r_ndc [2];

    // take sign and magnitude, flag quotients that would saturate
    always_comb begin
        logic signed [CLIP_W-1:0] c;
        logic [CLIP_W-1:0]        m;
        for (int l = 0; l < 2; l++) begin
            c = (l == 0) ? i_clip_x : i_clip_y;
            neg_in[l] = c[CLIP_W-1];
            m = neg_in[l] ? CLIP_W'(-c) : CLIP_W'(c);
            mag_in[l] = {m, {FRAC_BITS{1'b0}}};
            ovf_in[l] = CMP_W'(mag_in[l] >> QB) >= CMP_W'(i_clip_w[DIV_W-1:0]);
        end
    end

    // one trial subtraction per stage and lane
    always_comb begin
        logic [CMP_W-1:0] w_sh;
        logic [CMP_W-1:0] rem_ext;
        for (int l = 0; l < 2; l++) begin
            n_rem[l][0]  = '0;
            n_take[l][0] = 1'b0;
        end
        for (int s = 1; s <= QB; s++) begin
            w_sh = CMP_W'(r_div[s-1]) << (QB - s);
            for (int l = 0; l < 2; l++) begin
                rem_ext      = CMP_W'(r_rem[l][s-1]);
                n_take[l][s] = rem_ext >= w_sh;
                n_rem[l][s]  = n_take[l][s] ? NUM_W'(rem_ext - w_sh) : r_rem[l][s-1];
            end
        end
    end

    // advance the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QB; s++) begin
                r_tag[s] <= '0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            r_div[0] <= i_clip_w[DIV_W-1:0];
            for (int l = 0; l < 2; l++) begin
                r_rem[l][0] <= mag_in[l];
                r_quo[l][0] <= '0;
                r_neg[l][0] <= neg_in[l];
                r_ovf[l][0] <= ovf_in[l];
            end
            for (int s = 1; s <= QB; s++) begin
                r_tag[s] <= r_tag[s-1];
                r_div[s] <= r_div[s-1];
                for (int l = 0; l < 2; l++) begin
                    r_rem[l][s] <= n_rem[l][s];
                    r_quo[l][s] <= r_quo[l][s-1]
                                 | (n_take[l][s] ? (QB'(1) << (QB - s)) : QB'(0));
                    r_neg[l][s] <= r_neg[l][s-1];
                    r_ovf[l][s] <= r_ovf[l][s-1];
                end
            end
        end
    end

    // floor for negative dividends, clamp saturating quotients
    always_comb begin
        logic [NDC_W-1:0] m;
        for (int l = 0; l < 2; l++) begin
            if (r_ovf[l][QB]) begin
                m = NDC_W'(1) << QB;
            end else begin
                m = NDC_W'(r_quo[l][QB])
                  + NDC_W'(r_neg[l][QB] && (r_rem[l][QB] != '0));
            end
            n_ndc[l] = r_neg[l][QB] ? $signed(-m) : $signed(m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_out <= '0;
        end else if (i_en) begin
            r_tag_out <= r_tag[QB];
            r_ndc[0]  <= n_ndc[0];
            r_ndc[1]  <= n_ndc[1];
        end
    end

    assign o_tag   = r_tag_out;
    assign o_ndc_x = r_ndc[0];
    assign o_ndc_y = r_ndc[1];

endmodule

// File: rtl/wsp_screen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_screen
// Viewport mapping: scale ndc by half size + 1 (y: 1 - half size), add the
// offset, saturate. Two stages; the second is the output register.
// ----------------------------------------------------------------------------
module wsp_screen import wsp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_tag                     i_tag,
    input  logic signed [NDC_W-1:0]  i_ndc_x,
    input  logic signed [NDC_W-1:0]  i_ndc_y,
    input  logic [SIZE_W-1:0]        i_screen_width,
    input  logic [SIZE_W-1:0]        i_screen_height,
    output t_tag                     o_tag,
    output logic signed [OUT_W-1:0]  o_screen_x,
    output logic signed [OUT_W-1:0]  o_screen_y
);

    logic [HALF_W-1:0]         hw;
    logic [HALF_W-1:0]         hh;
    logic signed [COEF_W-1:0]  coef_x;
    logic signed [COEF_W-1:0]  coef_y;
    logic signed [SCR_W-1:0]   off_x;
    logic signed [SCR_W-1:0]   off_y;
    logic signed [SPROD_W-1:0] r_px;
    logic signed [SPROD_W-1:0] r_py;
    t_tag                      r_tag1;
    t_tag                      r_tag2;
    logic signed [OUT_W-1:0]   r_sx;
    logic signed [OUT_W-1:0]   r_sy;
    logic signed [OUT_W-1:0]   n_sx;
    logic signed [OUT_W-1:0]   n_sy;

    assign hw     = i_screen_width[SIZE_W-1:1];
    assign hh     = i_screen_height[SIZE_W-1:1];
    assign coef_x = $signed({2'b00, hw}) + COEF_W'(1);
    assign coef_y = COEF_W'(1) - $signed({2'b00, hh});
    assign off_x  = $signed(SCR_W'({hw, {FRAC_BITS{1'b0}}}));
    assign off_y  = $signed(SCR_W'({hh, {FRAC_BITS{1'b0}}}));

    // stage 1: scale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
        end else if (i_en) begin
            r_tag1 <= i_tag;
            r_px   <= SPROD_W'(coef_x) * SPROD_W'(i_ndc_x);
            r_py   <= SPROD_W'(coef_y) * SPROD_W'(i_ndc_y);
        end
    end

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [SCR_W-1:0] v);
        logic signed [SCR_W-1:0] hi;
        logic signed [SCR_W-1:0] lo;
        hi = SCR_W'({1'b0, {(OUT_W-1){1'b1}}});
        lo = -hi - SCR_W'(1);
        if (v > hi) begin
            sat = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (v < lo) begin
            sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat = v[OUT_W-1:0];
        end
    endfunction

    // add offset, saturate, zero hidden points
    always_comb begin
        n_sx = '0;
        n_sy = '0;
        if (r_tag1.visible) begin
            n_sx = sat($signed({r_px[SPROD_W-1], r_px}) + off_x);
            n_sy = sat($signed({r_py[SPROD_W-1], r_py}) + off_y);
        end
    end

    // stage 2: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2 <= '0;
        end else if (i_en) begin
            r_tag2 <= r_tag1;
            r_sx   <= n_sx;
            r_sy   <= n_sy;
        end
    end

    assign o_tag      = r_tag2;
    assign o_screen_x = r_sx;
    assign o_screen_y = r_sy;

endmodule

// File: rtl/world_to_screen_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Projects world points through a 4x4 Q16.16 view matrix to screen positions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) takes one request per cycle while
//   o_stall is low. A load request (operation 0) writes one matrix entry
//   and yields no result; a project request (operation 1) yields one
//   result on o_valid / i_stall. Later requests see earlier loads at once.
//   Screen size sits in two APB registers: width at 0x0, height at 0x4.
//   The pipe has two transform stages, one divider setup stage, 33 divider
//   stages (one quotient bit each), one ndc stage and two screen stages.
//   Throughput is one request per cycle while the pipe is not stalled.
//   Reset clears the matrix to zero, sets the size to 1920 x 1080 and
//   empties the pipe. While the receiver stalls a waiting result, the whole
//   pipe holds and o_stall is raised; while the output is empty, requests
//   keep flowing even if the receiver stalls.
// ----------------------------------------------------------------------------
module world_to_screen_projection import wsp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_operation,
    input  logic [IDX_W-1:0]          i_entry_index,
    input  logic signed [ENTRY_W-1:0] i_entry_value,
    input  logic signed [ENTRY_W-1:0] i_pos_x,
    input  logic signed [ENTRY_W-1:0] i_pos_y,
    input  logic signed [ENTRY_W-1:0] i_pos_z,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_visible,
    output logic signed [OUT_W-1:0]   o_screen_x,
    output logic signed [OUT_W-1:0]   o_screen_y,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    logic [SIZE_W-1:0]        r_screen_width;
    logic [SIZE_W-1:0]        r_screen_height;
    logic                     en;
    logic                     accept;
    t_tag                     clip_tag;
    t_tag                     div_tag;
    t_tag                     out_tag;
    logic signed [CLIP_W-1:0] clip_x;
    logic signed [CLIP_W-1:0] clip_y;
    logic signed [CLIP_W-1:0] clip_w;
    logic signed [NDC_W-1:0]  ndc_x;
    logic signed [NDC_W-1:0]  ndc_y;

    // hold the whole pipe only when a result waits on a stalled receiver
    assign en      = !out_tag.valid || !i_stall;
    assign o_stall = !en;
    assign accept  = i_valid && en;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= WIDTH_RESET;
            r_screen_height <= HEIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_WIDTH) begin
                r_screen_width <= pwdata[SIZE_W-1:0];
            end else begin
                r_screen_height <= pwdata[SIZE_W-1:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = DATA_W'(r_screen_width);
            REG_HEIGHT: prdata = DATA_W'(r_screen_height);
            default:    prdata = '0;
        endcase
    end

    wsp_clip u_clip (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_accept      (accept),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .o_tag         (clip_tag),
        .o_clip_x      (clip_x),
        .o_clip_y      (clip_y),
        .o_clip_w      (clip_w)
    );

    wsp_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_tag    (clip_tag),
        .i_clip_x (clip_x),
        .i_clip_y (clip_y),
        .i_clip_w (clip_w),
        .o_tag    (div_tag),
        .o_ndc_x  (ndc_x),
        .o_ndc_y  (ndc_y)
    );

    wsp_screen u_screen (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_tag           (div_tag),
        .i_ndc_x         (ndc_x),
        .i_ndc_y         (ndc_y),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .o_tag           (out_tag),
        .o_screen_x      (o_screen_x),
        .o_screen_y      (o_screen_y)
    );

    assign o_valid   = out_tag.valid;
    assign o_visible = out_tag.visible;

    // drop the pipe contents at reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // hidden points report a zero position
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_visible) |-> (o_screen_x == '0 && o_screen_y == '0))
        else $error("hidden point with nonzero position");

    // a stalled result holds the pipe and its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_screen_x) && $stable(o_screen_y)))
        else $error("stalled result changed");

    // no request is taken while a stalled result waits
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("request taken while output stalled");

endmodule
